@@ hw/rtl/tge_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the tensor gather engine: store depths, field widths,
// request and error codes. No dependencies.
package tge_pkg;

   localparam int INDEX_DEPTH = 256;
   localparam int DATA_DEPTH  = 4096;
   localparam int IDX_AW  = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
   localparam int DATA_AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

   localparam int FUNC_W  = 2;
   localparam int POS_W   = 20;
   localparam int WORD_W  = 32;
   localparam int ERR_W   = 2;
   localparam int CNT_W   = 17;
   localparam int ICNT_W  = 9;
   localparam int CSR_AW  = 2;

   localparam int REQ_DATA_W = ((POS_W + 2 * WORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = WORD_W;

   localparam int MUL_AW  = 26;
   localparam int MUL_BW  = CNT_W;
   localparam int MUL_PW  = MUL_AW + MUL_BW;
   localparam int DIV_CW  = $clog2(POS_W);

   localparam logic [FUNC_W-1:0] FUNC_LOAD_INDEX = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_DATA  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ       = 2'd2;

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_INDEX = 2'd1;
   localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_OUTER_COUNT = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_AXIS_LENGTH = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_INNER_COUNT = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_INDEX_COUNT = 2'd3;

endpackage

@@ hw/rtl/tge_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module tge_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/tensor_gather_engine.sv @@
`timescale 1ns / 1ps
// Gather engine top level: sequencer, shared multiplier, shared serial divider.
// Depends on tge_pkg and tge_ram.
//
// Usage:
//   csr_*  : register writes (0 outer_count, 1 axis_length, 2 inner_count,
//            3 index_count), always ready; write only while the engine is idle.
//   req_*  : one request per handshake; tuser selects load index entry,
//            load data word or read output element.
//   rsp_*  : exactly one response per request, in request order.
// Sequence: a load or unused request goes to the done state when accepted; its
//   response is registered once the response register is free. A read forms the
//   total from two products on the shared multiplier, runs two 20-step divisions
//   on the shared radix-2 divider, an index store read, two address multiply-adds
//   and a data store read. Reads that fail an early check finish sooner. One
//   request is in flight at a time; the next one can be accepted in the same
//   cycle as the response appears. The engine stalls before pushing its response
//   while the receiver has not taken the previous one, and accepts nothing meanwhile.
// Reset clears the registers to 1 and empties the pipeline; store contents
//   are undefined until written.
module tensor_gather_engine (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tge_pkg::CSR_AW-1:0]         csr_index,
   input  logic [tge_pkg::CNT_W-1:0]          csr_data,
   // requests
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tge_pkg::REQ_DATA_W-1:0]     req_tdata,  // position, index_value, data_word
   input  logic [tge_pkg::FUNC_W-1:0]         req_tuser,  // func
   // responses
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tge_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // element
   output logic [tge_pkg::ERR_W-1:0]          rsp_tuser   // error
);
   import tge_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_TOT1, S_TOT2, S_DIV1, S_DIV2, S_IDX_RD, S_IDX_CHK,
      S_MUL_A, S_MUL_B, S_DAT_RD, S_DAT_CHK, S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    outer_count_ff, outer_count_in;
   logic [CNT_W-1:0]    axis_length_ff, axis_length_in;
   logic [CNT_W-1:0]    inner_count_ff, inner_count_in;
   logic [ICNT_W-1:0]   index_count_ff, index_count_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [DIV_CW-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]    inner_ff, inner_in;
   logic [ICNT_W-1:0]   slot_ff, slot_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [MUL_PW-1:0]   acc_ff, acc_in;
   logic [DATA_AW-1:0]  addr_ff, addr_in;
   logic [WORD_W-1:0]   res_elem_ff, res_elem_in;
   logic [ERR_W-1:0]    res_err_ff, res_err_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   rsp_elem_ff, rsp_elem_in;
   logic [ERR_W-1:0]    rsp_err_ff, rsp_err_in;

   logic [POS_W-1:0]    req_pos;
   logic [WORD_W-1:0]   req_index_value;
   logic [WORD_W-1:0]   req_data_word;
   logic                req_accept;
   logic                idx_wr_en, dat_wr_en;
   logic                pos_in_idx, pos_in_dat;
   logic [WORD_W-1:0]   idx_rd_data, dat_rd_data;
   logic [MUL_AW-1:0]   mul_a;
   logic [MUL_BW-1:0]   mul_b;
   logic [MUL_PW-1:0]   product;
   logic [CNT_W-1:0]    div_den;
   logic [CNT_W:0]      div_trial;
   logic                div_ge;
   logic [CNT_W-1:0]    div_rem;
   logic [POS_W-1:0]    div_quo;
   logic signed [WORD_W:0] idx_norm;
   logic                rsp_free;

   assign req_pos         = req_tdata[POS_W-1:0];
   assign req_index_value = req_tdata[POS_W+WORD_W-1:POS_W];
   assign req_data_word   = req_tdata[POS_W+2*WORD_W-1:POS_W+WORD_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign pos_in_idx = ({1'b0, req_pos} < (POS_W+1)'(INDEX_DEPTH));
   assign pos_in_dat = ({1'b0, req_pos} < (POS_W+1)'(DATA_DEPTH));
   assign idx_wr_en  = req_accept && (req_tuser == FUNC_LOAD_INDEX) && pos_in_idx;
   assign dat_wr_en  = req_accept && (req_tuser == FUNC_LOAD_DATA) && pos_in_dat;

   tge_ram #(.WIDTH(WORD_W), .DEPTH(INDEX_DEPTH)) u_index_store (
      .clock   (clock),
      .wr_en   (idx_wr_en),
      .wr_addr (req_pos[IDX_AW-1:0]),
      .wr_data (req_index_value),
      .rd_addr (slot_ff[IDX_AW-1:0]),
      .rd_data (idx_rd_data)
   );

   tge_ram #(.WIDTH(WORD_W), .DEPTH(DATA_DEPTH)) u_data_store (
      .clock   (clock),
      .wr_en   (dat_wr_en),
      .wr_addr (req_pos[DATA_AW-1:0]),
      .wr_data (req_data_word),
      .rd_addr (addr_ff),
      .rd_data (dat_rd_data)
   );

   // shared multiplier
   always_comb begin
      case (state_ff)
         S_TOT1: begin
            mul_a = MUL_AW'(outer_count_ff);
            mul_b = MUL_BW'(index_count_ff);
         end
         S_TOT2: begin
            mul_a = acc_ff[MUL_AW-1:0];
            mul_b = inner_count_ff;
         end
         S_MUL_A: begin
            mul_a = MUL_AW'(quo_ff);
            mul_b = axis_length_ff;
         end
         S_MUL_B: begin
            mul_a = MUL_AW'(acc_ff[DATA_AW-1:0]);
            mul_b = inner_count_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign product = MUL_PW'(mul_a) * MUL_PW'(mul_b);

   // shared restoring divider step
   assign div_den   = (state_ff == S_DIV2) ? CNT_W'(index_count_ff) : inner_count_ff;
   assign div_trial = {rem_ff, quo_ff[POS_W-1]};
   assign div_ge    = (div_trial >= {1'b0, div_den});
   assign div_rem   = div_ge ? CNT_W'(div_trial - {1'b0, div_den}) : div_trial[CNT_W-1:0];
   assign div_quo   = {quo_ff[POS_W-2:0], div_ge};

   assign idx_norm = idx_rd_data[WORD_W-1]
                   ? ($signed({idx_rd_data[WORD_W-1], idx_rd_data})
                      + $signed({16'b0, axis_length_ff}))
                   : $signed({1'b0, idx_rd_data});

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in       = state_ff;
      outer_count_in = outer_count_ff;
      axis_length_in = axis_length_ff;
      inner_count_in = inner_count_ff;
      index_count_in = index_count_ff;
      pos_in         = pos_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      inner_in       = inner_ff;
      slot_in        = slot_ff;
      idx_in         = idx_ff;
      acc_in         = acc_ff;
      addr_in        = addr_ff;
      res_elem_in    = res_elem_ff;
      res_err_in     = res_err_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_elem_in    = rsp_elem_ff;
      rsp_err_in     = rsp_err_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OUTER_COUNT: outer_count_in = csr_data;
            CSR_AXIS_LENGTH: axis_length_in = csr_data;
            CSR_INNER_COUNT: inner_count_in = csr_data;
            CSR_INDEX_COUNT: index_count_in = csr_data[ICNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               pos_in      = req_pos;
               res_elem_in = '0;
               res_err_in  = ERR_NONE;
               state_in    = S_DONE;
               case (req_tuser)
                  FUNC_LOAD_INDEX: if (!pos_in_idx) res_err_in = ERR_RANGE;
                  FUNC_LOAD_DATA:  if (!pos_in_dat) res_err_in = ERR_RANGE;
                  FUNC_READ: begin
                     if (outer_count_ff == '0 || inner_count_ff == '0 ||
                         index_count_ff == '0) begin
                        res_err_in = ERR_RANGE;
                     end else begin
                        state_in = S_TOT1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TOT1: begin
            acc_in   = product;
            state_in = S_TOT2;
         end
         S_TOT2: begin
            if (MUL_PW'(pos_ff) >= product) begin
               res_err_in = ERR_RANGE;
               state_in   = S_DONE;
            end else begin
               quo_in   = pos_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            quo_in = div_quo;
            rem_in = div_rem;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CW'(POS_W - 1)) begin
               inner_in = div_rem;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            quo_in = div_quo;
            rem_in = div_rem;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CW'(POS_W - 1)) begin
               cnt_in  = '0;
               slot_in = div_rem[ICNT_W-1:0];
               if (32'(div_rem[ICNT_W-1:0]) >= 32'(INDEX_DEPTH)) begin
                  res_err_in = ERR_RANGE;
                  state_in   = S_DONE;
               end else begin
                  state_in = S_IDX_RD;
               end
            end
         end
         S_IDX_RD: begin
            state_in = S_IDX_CHK;
         end
         S_IDX_CHK: begin
            if (idx_norm[WORD_W] || (idx_norm[WORD_W-1:0] >= WORD_W'(axis_length_ff))) begin
               res_err_in = ERR_INDEX;
               state_in   = S_DONE;
            end else begin
               idx_in   = idx_norm[CNT_W-1:0];
               state_in = S_MUL_A;
            end
         end
         S_MUL_A: begin
            acc_in   = product + MUL_PW'(idx_ff);
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            // address grows with acc since inner_count is at least one
            if (acc_ff >= MUL_PW'(DATA_DEPTH) ||
                (product + MUL_PW'(inner_ff)) >= MUL_PW'(DATA_DEPTH)) begin
               res_err_in = ERR_RANGE;
               state_in   = S_DONE;
            end else begin
               addr_in  = DATA_AW'(product + MUL_PW'(inner_ff));
               state_in = S_DAT_RD;
            end
         end
         S_DAT_RD: begin
            state_in = S_DAT_CHK;
         end
         S_DAT_CHK: begin
            res_elem_in = dat_rd_data;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_elem_in  = res_elem_ff;
               rsp_err_in   = res_err_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         outer_count_ff <= CNT_W'(1);
         axis_length_ff <= CNT_W'(1);
         inner_count_ff <= CNT_W'(1);
         index_count_ff <= ICNT_W'(1);
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         outer_count_ff <= outer_count_in;
         axis_length_ff <= axis_length_in;
         inner_count_ff <= inner_count_in;
         index_count_ff <= index_count_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      inner_ff    <= inner_in;
      slot_ff     <= slot_in;
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      addr_ff     <= addr_in;
      res_elem_ff <= res_elem_in;
      res_err_ff  <= res_err_in;
      rsp_elem_ff <= rsp_elem_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_elem_ff;
   assign rsp_tuser  = rsp_err_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request accepted while engine busy");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV1 || state_ff == S_DIV2) |-> (cnt_ff < DIV_CW'(POS_W)))
      else $error("divider step count overrun");

   a_slot_in_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDX_RD) |-> (32'(slot_ff) < 32'(INDEX_DEPTH)))
      else $error("index store read beyond depth");

   a_push_from_done: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_tready) && (state_ff == S_DONE) |=> rsp_valid_ff)
      else $error("finished result not pushed");

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      (idx_wr_en || dat_wr_en) |-> (state_ff == S_IDLE))
      else $error("store write outside idle");
`endif

endmodule
